// ----- sv/bcp_pkg.sv -----
// ----------------------------------------------------------------------------
// bcp_pkg
// shared types and codes for the batch completion counter pool
// ----------------------------------------------------------------------------
`default_nettype none

package bcp_pkg;

   localparam int COUNT_W = 8;
   localparam int EPOCH_W = 16;
   localparam int TIME_W  = 32;
   localparam int SLOT_W  = 4;
   localparam int MASK_W  = 16;
   localparam int TOKEN_W = 8;
   localparam int STAT_W  = 3;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd100000;

   // item operation codes
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_REPLY = 1'b1;

   typedef enum logic [STAT_W-1:0] {
      STAT_ALLOCATED = 3'd0,
      STAT_POOL_FULL = 3'd1,
      STAT_COUNTED   = 3'd2,
      STAT_DONE      = 3'd3,
      STAT_INACTIVE  = 3'd4,
      STAT_STALE     = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_GRANT,
      S_RD,
      S_UPD
   } state_type;

   // one entry of the count / epoch memory
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [EPOCH_W-1:0] epoch;
   } entry_type;

endpackage

`default_nettype wire

// ----- sv/bcp_slot_store.sv -----
// ----------------------------------------------------------------------------
// bcp_slot_store
// per-slot storage: allocation timestamps and count / epoch entries, one
// write port and one registered read port shared by both memories
// ----------------------------------------------------------------------------
`default_nettype none

module bcp_slot_store #(
   parameter  int NUM_SLOTS = 16,
   localparam int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
   input  wire logic                         clock,
   input  wire logic [SW-1:0]                wr_addr,
   input  wire logic [SW-1:0]                rd_addr,
   input  wire logic                         ts_we,
   input  wire logic [bcp_pkg::TIME_W-1:0]   ts_wdata,
   input  wire logic                         ent_we,
   input  wire bcp_pkg::entry_type           ent_wdata,
   output logic      [bcp_pkg::TIME_W-1:0]   ts_rdata,
   output bcp_pkg::entry_type                ent_rdata
);

   logic [bcp_pkg::TIME_W-1:0] ts_mem [NUM_SLOTS];
   bcp_pkg::entry_type         ent_mem [NUM_SLOTS];

   logic [bcp_pkg::TIME_W-1:0] ts_rd_ff;
   bcp_pkg::entry_type         ent_rd_ff;

   always_ff @(posedge clock) begin
      if (ts_we) begin
         ts_mem[wr_addr] <= ts_wdata;
      end
      if (ent_we) begin
         ent_mem[wr_addr] <= ent_wdata;
      end
      ts_rd_ff  <= ts_mem[rd_addr];
      ent_rd_ff <= ent_mem[rd_addr];
   end

   assign ts_rdata  = ts_rd_ff;
   assign ent_rdata = ent_rd_ff;

endmodule

`default_nettype wire

// ----- sv/batch_completion_counter_pool_core.sv -----
// ----------------------------------------------------------------------------
// batch_completion_counter_pool_core
// pool of batch counters with generation-tagged tokens and timeout release
// ----------------------------------------------------------------------------
// usage
//   an item is taken when start is high and busy is low; busy stays high
//   while the item is worked on and drops in the cycle its result shows
//   each item gives one result beat on the rsp_ ports, marked by
//   rsp_strobe for exactly one cycle; the receiver cannot stall it
//   allocate: the timestamp memory is swept one slot per cycle through
//   the registered read port, releasing timed-out slots, then the lowest
//   free slot is granted; a new item can be taken at the edge that ends
//   the strobe cycle, not before
//   reply: one memory read, then, if the slot is in range and active and
//   the epoch matches, a write-back of the decremented count; an inactive
//   or out-of-range slot is answered without a write; only one item is in
//   flight, so accesses never overlap
//   csr_wr_en / csr_wr_data write timeout_ff; the user must do so only
//   while idle, as the block itself does not enforce it
//   reset clears active flags, epoch counter and the strobe, and loads the
//   timeout with 100000; memories need no clearing since an entry is only
//   used while its slot is active
// ----------------------------------------------------------------------------
`default_nettype none

module batch_completion_counter_pool_core #(
   parameter int NUM_SLOTS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // configuration
   input  wire logic                           csr_wr_en,
   input  wire logic [bcp_pkg::TIME_W-1:0]     csr_wr_data,
   // request channel
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_operation,
   input  wire logic [bcp_pkg::COUNT_W-1:0]    req_batch_total,
   input  wire logic [bcp_pkg::TOKEN_W-1:0]    req_token_slot,
   input  wire logic [bcp_pkg::EPOCH_W-1:0]    req_token_epoch,
   input  wire logic [bcp_pkg::TIME_W-1:0]     req_current_time,
   // response channel
   output logic                                rsp_strobe,
   output logic      [bcp_pkg::STAT_W-1:0]     rsp_status,
   output logic      [bcp_pkg::SLOT_W-1:0]     rsp_granted_slot,
   output logic      [bcp_pkg::EPOCH_W-1:0]    rsp_granted_epoch,
   output logic      [bcp_pkg::MASK_W-1:0]     rsp_reaped_mask
);

   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam logic [CW-1:0] SCAN_END = CW'(NUM_SLOTS);
   localparam logic [bcp_pkg::TOKEN_W-1:0] SLOT_LIMIT = bcp_pkg::TOKEN_W'(NUM_SLOTS);

   // control state
   bcp_pkg::state_type state_ff, state_in;
   logic [NUM_SLOTS-1:0]          active_ff, active_in;
   logic [bcp_pkg::EPOCH_W-1:0]   epoch_ctr_ff, epoch_ctr_in;
   logic [bcp_pkg::TIME_W-1:0]    timeout_ff;
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic                          chk_vld_ff, chk_vld_in;
   logic [SW-1:0]                 chk_idx_ff, chk_idx_in;
   logic [bcp_pkg::MASK_W-1:0]    reap_ff, reap_in;

   // captured item
   logic [bcp_pkg::COUNT_W-1:0]   total_ff;
   logic [bcp_pkg::TOKEN_W-1:0]   tok_slot_ff;
   logic [bcp_pkg::EPOCH_W-1:0]   tok_epoch_ff;
   logic [bcp_pkg::TIME_W-1:0]    now_ff;

   // result beat registers
   logic                          rsp_strobe_ff, rsp_strobe_in;
   bcp_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [bcp_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [bcp_pkg::EPOCH_W-1:0]   rsp_epoch_ff, rsp_epoch_in;
   logic [bcp_pkg::MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;

   // store interface
   logic [SW-1:0]                 wr_addr, rd_addr;
   logic                          ts_we, ent_we;
   logic [bcp_pkg::TIME_W-1:0]    ts_wdata, ts_rdata;
   bcp_pkg::entry_type            ent_wdata, ent_rdata;

   logic                          accept;
   logic                          any_free;
   logic [SW-1:0]                 free_idx;
   logic [SW-1:0]                 tok_idx;
   logic [bcp_pkg::TIME_W-1:0]    age;
   logic [bcp_pkg::COUNT_W-1:0]   count_dec;
   logic [bcp_pkg::EPOCH_W-1:0]   epoch_next;

   assign busy     = (state_ff != bcp_pkg::S_IDLE);
   assign accept   = start && !busy;
   assign tok_idx  = tok_slot_ff[SW-1:0];
   assign age      = now_ff - ts_rdata;
   assign count_dec = ent_rdata.count - 8'd1;
   assign epoch_next = epoch_ctr_ff + 16'd1;

   bcp_slot_store #(
      .NUM_SLOTS (NUM_SLOTS)
   ) u_store (
      .clock     (clock),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .ts_we     (ts_we),
      .ts_wdata  (ts_wdata),
      .ent_we    (ent_we),
      .ent_wdata (ent_wdata),
      .ts_rdata  (ts_rdata),
      .ent_rdata (ent_rdata)
   );

   // lowest free slot, after the sweep has dropped timed-out slots
   always_comb begin
      any_free = 1'b0;
      free_idx = '0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!active_ff[i]) begin
            any_free = 1'b1;
            free_idx = SW'(i);
         end
      end
   end

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      active_in     = active_ff;
      epoch_ctr_in  = epoch_ctr_ff;
      cnt_in        = cnt_ff;
      chk_vld_in    = 1'b0;
      chk_idx_in    = chk_idx_ff;
      reap_in       = reap_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_epoch_in  = rsp_epoch_ff;
      rsp_mask_in   = rsp_mask_ff;
      wr_addr       = free_idx;
      rd_addr       = cnt_ff[SW-1:0];
      ts_we         = 1'b0;
      ent_we        = 1'b0;
      ts_wdata      = now_ff;
      ent_wdata     = '{count: total_ff, epoch: epoch_next};

      case (state_ff)
         bcp_pkg::S_IDLE: begin
            if (accept) begin
               if (req_operation == bcp_pkg::OP_ALLOC) begin
                  cnt_in   = '0;
                  reap_in  = '0;
                  state_in = bcp_pkg::S_SCAN;
               end else begin
                  state_in = bcp_pkg::S_RD;
               end
            end
         end

         bcp_pkg::S_SCAN: begin
            // check stage: timestamp of the slot read last cycle
            if (chk_vld_ff && active_ff[chk_idx_ff] && (age > timeout_ff)) begin
               active_in[chk_idx_ff] = 1'b0;
               reap_in[chk_idx_ff]   = 1'b1;
            end
            // read stage
            if (cnt_ff != SCAN_END) begin
               rd_addr    = cnt_ff[SW-1:0];
               chk_vld_in = 1'b1;
               chk_idx_in = cnt_ff[SW-1:0];
               cnt_in     = cnt_ff + CW'(1);
            end else begin
               state_in = bcp_pkg::S_GRANT;
            end
         end

         bcp_pkg::S_GRANT: begin
            rsp_strobe_in = 1'b1;
            rsp_mask_in   = reap_ff;
            if (any_free) begin
               wr_addr             = free_idx;
               ts_we               = 1'b1;
               ent_we              = 1'b1;
               active_in[free_idx] = 1'b1;
               epoch_ctr_in        = epoch_next;
               rsp_status_in       = bcp_pkg::STAT_ALLOCATED;
               rsp_slot_in         = bcp_pkg::SLOT_W'(free_idx);
               rsp_epoch_in        = epoch_next;
            end else begin
               rsp_status_in = bcp_pkg::STAT_POOL_FULL;
               rsp_slot_in   = '0;
               rsp_epoch_in  = '0;
            end
            state_in = bcp_pkg::S_IDLE;
         end

         bcp_pkg::S_RD: begin
            rd_addr = tok_idx;
            if ((tok_slot_ff >= SLOT_LIMIT) || !active_ff[tok_idx]) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bcp_pkg::STAT_INACTIVE;
               rsp_slot_in   = '0;
               rsp_epoch_in  = '0;
               rsp_mask_in   = '0;
               state_in      = bcp_pkg::S_IDLE;
            end else begin
               state_in = bcp_pkg::S_UPD;
            end
         end

         bcp_pkg::S_UPD: begin
            rsp_strobe_in = 1'b1;
            rsp_slot_in   = '0;
            rsp_epoch_in  = '0;
            rsp_mask_in   = '0;
            if (ent_rdata.epoch != tok_epoch_ff) begin
               rsp_status_in = bcp_pkg::STAT_STALE;
            end else begin
               // count write-back, wrapping below zero
               wr_addr   = tok_idx;
               ent_we    = 1'b1;
               ent_wdata = '{count: count_dec, epoch: ent_rdata.epoch};
               if (count_dec == '0) begin
                  active_in[tok_idx] = 1'b0;
                  rsp_status_in      = bcp_pkg::STAT_DONE;
               end else begin
                  rsp_status_in = bcp_pkg::STAT_COUNTED;
               end
            end
            state_in = bcp_pkg::S_IDLE;
         end

         default: begin
            state_in = bcp_pkg::S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bcp_pkg::S_IDLE;
         active_ff     <= '0;
         epoch_ctr_ff  <= '0;
         timeout_ff    <= bcp_pkg::TIMEOUT_RESET;
         cnt_ff        <= '0;
         chk_vld_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         active_ff     <= active_in;
         epoch_ctr_ff  <= epoch_ctr_in;
         cnt_ff        <= cnt_in;
         chk_vld_ff    <= chk_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            timeout_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         total_ff     <= req_batch_total;
         tok_slot_ff  <= req_token_slot;
         tok_epoch_ff <= req_token_epoch;
         now_ff       <= req_current_time;
      end
      chk_idx_ff    <= chk_idx_in;
      reap_ff       <= reap_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_epoch_ff  <= rsp_epoch_in;
      rsp_mask_ff   <= rsp_mask_in;
   end

   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_granted_slot  = rsp_slot_ff;
   assign rsp_granted_epoch = rsp_epoch_ff;
   assign rsp_reaped_mask   = rsp_mask_ff;

endmodule

`default_nettype wire
